@@ hdl/vsls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viscoelastic SLS package
// Shared constants, types and fixed-point helpers for the stress update.
// ----------------------------------------------------------------------------
package vsls_pkg;

  localparam int DefPointCount = 1024;
  localparam int DefValueWidth = 32;
  localparam int PointIdxW     = 10;
  localparam int ComponentCount = 6;

  // Configuration register indexes.
  localparam logic [2:0] REG_MU    = 3'd0;
  localparam logic [2:0] REG_K     = 3'd1;
  localparam logic [2:0] REG_GI    = 3'd2;
  localparam logic [2:0] REG_GV    = 3'd3;
  localparam logic [2:0] REG_DF    = 3'd4;
  localparam logic [2:0] REG_DH    = 3'd5;
  localparam logic [2:0] REG_ALPHA = 3'd6;
  localparam logic [2:0] REG_SOR   = 3'd7;

  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_STEADY  = 1'b1;

  typedef struct packed {
    logic [30:0] mu;
    logic [30:0] k;
    logic [16:0] gi;
    logic [16:0] gv;
    logic [16:0] df;
    logic [16:0] dh;
    logic [30:0] alpha;
    logic [30:0] sor;
  } cfg_t;

  // One classified request handed from the front part to the back part.
  typedef struct packed {
    logic                 steady;
    logic [PointIdxW-1:0] point;
    logic signed [31:0]   theta;
    logic signed [31:0]   e0, e1, e2, e3, e4, e5;
  } req_t;

  // Saturate a 64-bit signed value to the given signed width (w <= 32).
  function automatic logic signed [31:0] sat_w(input logic signed [63:0] x, input int w);
    logic signed [63:0] m;
    m = (64'sd1 <<< (w - 1)) - 64'sd1;
    if (x > m) sat_w = 32'(m);
    else if (x < -m - 64'sd1) sat_w = 32'(-m - 64'sd1);
    else sat_w = 32'(x);
  endfunction

  // Rescale by 2^sh, round to nearest with ties toward +infinity.
  function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int sh);
    rnd = (x + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

endpackage

@@ hdl/vsls_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viscoelastic SLS front stage
// Accepts requests, drops out-of-range points and forms the trace and the
// deviatoric strain into a short queue.
// ----------------------------------------------------------------------------
module vsls_front import vsls_pkg::*; #(
  parameter int POINT_COUNT = DefPointCount,
  parameter int VW          = DefValueWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [PointIdxW-1:0]  point_index,
  input  logic signed [31:0]    grad_xx, grad_xy, grad_xz,
  input  logic signed [31:0]    grad_yx, grad_yy, grad_yz,
  input  logic signed [31:0]    grad_zx, grad_zy, grad_zz,
  output logic                  q_valid,
  input  logic                  q_ready,
  output req_t                  q_data
);

  localparam int QDepth = 4;
  // Rounded-up 2^33 / 3; exact floor of a third for any 32-bit magnitude.
  localparam logic [31:0] RecipThird = 32'hAAAA_AAAB;

  req_t               fifo [QDepth];
  logic [1:0]         wr_ptr, rd_ptr;
  logic [2:0]         count;
  req_t               req_next;
  logic signed [63:0] tr_sum, t3, tmp;
  logic [31:0]        mag;
  logic [63:0]        prod;
  logic               push, pop, in_range, neg;

  assign in_ready = (count != 3'(QDepth));
  assign in_range = ({22'd0, point_index} < 32'(POINT_COUNT));
  assign push     = in_valid && in_ready && in_range;
  assign pop      = q_valid && q_ready;
  assign q_valid  = (count != 3'd0);
  assign q_data   = fifo[rd_ptr];

  // Trace, its third, and the symmetric deviatoric strain.
  always_comb begin
    req_next.steady = (opcode == OP_STEADY);
    req_next.point  = point_index;
    tr_sum = 64'(grad_xx) + 64'(grad_yy) + 64'(grad_zz);
    req_next.theta = sat_w(tr_sum, VW);
    // Floor of (theta + 1) / 3: a negative value uses the magnitude plus two.
    tmp  = 64'(req_next.theta) + 64'sd1;
    neg  = tmp[63];
    mag  = neg ? 32'(64'sd2 - tmp) : 32'(tmp);
    prod = 64'(mag) * 64'(RecipThird);
    t3   = 64'(prod[63:33]);
    if (neg) t3 = -t3;
    req_next.e0 = sat_w(64'(grad_xx) - t3, VW);
    req_next.e1 = sat_w(64'(grad_yy) - t3, VW);
    req_next.e2 = sat_w(64'(grad_zz) - t3, VW);
    req_next.e3 = sat_w(rnd(64'(grad_xy) + 64'(grad_yx), 1), VW);
    req_next.e4 = sat_w(rnd(64'(grad_yz) + 64'(grad_zy), 1), VW);
    req_next.e5 = sat_w(rnd(64'(grad_xz) + 64'(grad_zx), 1), VW);
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= req_next;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

@@ hdl/vsls_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viscoelastic SLS back stage
// Reads and updates the per-point state and produces the stress and energy.
// ----------------------------------------------------------------------------
module vsls_back import vsls_pkg::*; #(
  parameter int POINT_COUNT = DefPointCount,
  parameter int VW          = DefValueWidth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  req_t                 q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PointIdxW-1:0] result_point,
  output logic signed [31:0]   stress_xx, stress_yy, stress_zz,
  output logic signed [31:0]   stress_xy, stress_yz, stress_xz,
  output logic signed [47:0]   energy_total
);

  localparam int AW   = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
  localparam int RowW = ComponentCount * 32;
  localparam logic signed [63:0] VMax = (64'sd1 <<< (VW - 1)) - 64'sd1;

  // Per-point state rows, read through registers one address per cycle while the pipeline advances.
  logic [RowW-1:0] hist_mem [POINT_COUNT];
  logic [RowW-1:0] dev_mem  [POINT_COUNT];
  logic [47:0]     en_mem   [POINT_COUNT];

  logic [AW:0]        clr_cnt;
  logic               clearing, adv, go;
  logic [AW-1:0]      addr0, addr1, addr4, addr5;
  logic signed [63:0] ek_full;
  logic [31:0]        ek_r;
  logic signed [31:0] e_in [ComponentCount];
  logic signed [31:0] s0   [ComponentCount];

  // Stage 1: state read back, history update.
  logic                 p1_valid, p1_steady;
  logic [PointIdxW-1:0] p1_point;
  logic signed [31:0]   p1_theta;
  logic signed [31:0]   p1_e [ComponentCount];
  logic signed [31:0]   p1_s [ComponentCount];
  logic [RowW-1:0]      h_rd, d_rd, h_old, d_old, h_row, s_row;
  logic signed [31:0]   h_prev, d_prev;
  logic signed [31:0]   h1 [ComponentCount];
  logic signed [63:0]   vol1;
  logic                 fw_valid, fw_hit;
  logic [AW-1:0]        fw_addr;
  logic [RowW-1:0]      fw_h, fw_d;

  // Stage 2: stresses and energy factors.
  logic                 p2_valid;
  logic [PointIdxW-1:0] p2_point;
  logic signed [63:0]   p2_vol, sg;
  logic signed [31:0]   p2_e [ComponentCount];
  logic signed [31:0]   p2_s [ComponentCount];
  logic signed [31:0]   p2_h [ComponentCount];
  logic signed [31:0]   sig2 [ComponentCount];
  logic signed [31:0]   q2   [ComponentCount];
  logic signed [31:0]   qr2  [ComponentCount];

  // Stage 3: scaled energy factors.
  logic                 p3_valid;
  logic [PointIdxW-1:0] p3_point;
  logic signed [31:0]   p3_sig [ComponentCount];
  logic signed [31:0]   p3_e   [ComponentCount];
  logic signed [31:0]   p3_q   [ComponentCount];
  logic signed [31:0]   p3_qr  [ComponentCount];
  logic signed [31:0]   a3     [ComponentCount];
  logic signed [31:0]   qrdt3  [ComponentCount];

  // Stage 4: energy increment.
  logic                 p4_valid;
  logic [PointIdxW-1:0] p4_point;
  logic signed [31:0]   p4_sig  [ComponentCount];
  logic signed [31:0]   p4_a    [ComponentCount];
  logic signed [31:0]   p4_qrdt [ComponentCount];
  logic signed [63:0]   term, etot4;

  // Stage 5: energy accumulation.
  logic                 p5_valid;
  logic [PointIdxW-1:0] p5_point;
  logic signed [31:0]   p5_sig [ComponentCount];
  logic signed [63:0]   p5_etot, en_sum;
  logic [47:0]          en_rd, en_old, en_new;
  logic                 fw_e_valid, fw_e_hit;
  logic [AW-1:0]        fw_e_addr;
  logic [47:0]          fw_e_data;

  // The whole back pipeline moves only when the output register can move.
  assign clearing = (clr_cnt != (AW+1)'(POINT_COUNT));
  assign adv      = !out_valid || out_ready;
  assign q_ready  = !clearing && adv;
  assign go       = q_valid && q_ready;
  assign addr0    = AW'(q_data.point);
  assign addr1    = AW'(p1_point);
  assign addr4    = AW'(p4_point);
  assign addr5    = AW'(p5_point);

  // Stage 0: deviatoric stress and the clamped volumetric stiffness.
  always_comb begin
    e_in[0] = q_data.e0; e_in[1] = q_data.e1; e_in[2] = q_data.e2;
    e_in[3] = q_data.e3; e_in[4] = q_data.e4; e_in[5] = q_data.e5;
    for (int k = 0; k < ComponentCount; k++) begin
      s0[k] = sat_w(rnd(64'($signed({1'b0, cfg.mu})) * 64'(e_in[k]), 15), VW);
    end
    ek_full = rnd(64'($signed({1'b0, cfg.gi})) * 64'($signed({1'b0, cfg.k})), 16);
    if (ek_full < 0) ek_full = '0;
    if (ek_full > VMax) ek_full = VMax;
  end

  // Stage 1: history update; the latest row write is forwarded.
  always_comb begin
    fw_hit = fw_valid && (fw_addr == addr1);
    h_old  = fw_hit ? fw_h : h_rd;
    d_old  = fw_hit ? fw_d : d_rd;
    for (int k = 0; k < ComponentCount; k++) begin
      h_prev = h_old[k*32 +: 32];
      d_prev = d_old[k*32 +: 32];
      h1[k] = sat_w(rnd(64'($signed({1'b0, cfg.df})) * 64'(h_prev)
                        + 64'($signed({1'b0, cfg.dh})) * (64'(p1_s[k]) - 64'(d_prev)),
                        16), VW);
      h_row[k*32 +: 32] = p1_steady ? 32'd0 : h1[k];
      s_row[k*32 +: 32] = p1_s[k];
    end
    vol1 = rnd($signed(64'(ek_r)) * 64'(p1_theta), 16);
  end

  // Stage 2: output stress and the viscous factors.
  always_comb begin
    for (int k = 0; k < ComponentCount; k++) begin
      sg = rnd(64'($signed({1'b0, cfg.gi})) * 64'(p2_s[k])
               + 64'($signed({1'b0, cfg.gv})) * 64'(p2_h[k]), 16);
      if (k < 3) sg = sg + p2_vol;
      sig2[k] = sat_w(sg, VW);
      q2[k]   = sat_w(rnd(64'($signed({1'b0, cfg.gv}))
                          * (64'(p2_s[k]) - 64'(p2_h[k])), 16), VW);
      qr2[k]  = sat_w(rnd(64'($signed({1'b0, cfg.gv})) * 64'(p2_h[k]), 16), VW);
    end
  end

  // Stage 3: strain less alpha times q, and the rate-scaled viscous stress.
  always_comb begin
    for (int k = 0; k < ComponentCount; k++) begin
      a3[k] = sat_w(64'(p3_e[k])
                    - 64'(sat_w(rnd(64'($signed({1'b0, cfg.alpha})) * 64'(p3_q[k]), 16),
                                VW)), VW);
      qrdt3[k] = sat_w(rnd(64'(p3_qr[k]) * 64'($signed({1'b0, cfg.sor})), 16), VW);
    end
  end

  // Stage 4: double contraction, off-diagonal terms counted twice.
  always_comb begin
    etot4 = '0;
    term  = '0;
    for (int k = 0; k < ComponentCount; k++) begin
      term  = rnd(64'(p4_a[k]) * 64'(p4_qrdt[k]), 16);
      etot4 = etot4 + ((k < 3) ? term : (term <<< 1));
    end
  end

  // Stage 5: saturating energy accumulation with the latest write forwarded.
  always_comb begin
    fw_e_hit = fw_e_valid && (fw_e_addr == addr5);
    en_old   = fw_e_hit ? fw_e_data : en_rd;
    en_sum   = 64'($signed(en_old)) + p5_etot;
    if (en_sum > 64'sh7FFF_FFFF_FFFF) en_new = 48'h7FFF_FFFF_FFFF;
    else if (en_sum < -64'sh8000_0000_0000) en_new = 48'h8000_0000_0000;
    else en_new = en_sum[47:0];
  end

  // History and deviatoric memories, with a clearing pass after reset.
  always_ff @(posedge clk) begin
    if (clearing) begin
      hist_mem[clr_cnt[AW-1:0]] <= '0;
      dev_mem[clr_cnt[AW-1:0]]  <= '0;
    end else if (adv && p1_valid) begin
      hist_mem[addr1] <= h_row;
      dev_mem[addr1]  <= s_row;
    end
    if (adv) begin
      h_rd <= hist_mem[addr0];
      d_rd <= dev_mem[addr0];
    end
  end

  // Energy memory, read one stage ahead of its update.
  always_ff @(posedge clk) begin
    if (clearing) en_mem[clr_cnt[AW-1:0]] <= '0;
    else if (adv && p5_valid) en_mem[addr5] <= en_new;
    if (adv) en_rd <= en_mem[addr4];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (clearing) clr_cnt <= clr_cnt + (AW+1)'(1);
  end

  // Pipeline and forwarding valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid   <= 1'b0;
      p2_valid   <= 1'b0;
      p3_valid   <= 1'b0;
      p4_valid   <= 1'b0;
      p5_valid   <= 1'b0;
      out_valid  <= 1'b0;
      fw_valid   <= 1'b0;
      fw_e_valid <= 1'b0;
    end else if (adv) begin
      p1_valid  <= go;
      p2_valid  <= p1_valid && !p1_steady;
      p3_valid  <= p2_valid;
      p4_valid  <= p3_valid;
      p5_valid  <= p4_valid;
      out_valid <= p5_valid;
      if (p1_valid) fw_valid <= 1'b1;
      if (p5_valid) fw_e_valid <= 1'b1;
    end
  end

  // Pipeline data, forwarding data and the output register.
  always_ff @(posedge clk) begin
    ek_r <= ek_full[31:0];
    if (adv) begin
      p1_steady <= q_data.steady;
      p1_point  <= q_data.point;
      p1_theta  <= q_data.theta;
      p2_point  <= p1_point;
      p2_vol    <= vol1;
      p3_point  <= p2_point;
      p4_point  <= p3_point;
      p5_point  <= p4_point;
      p5_etot   <= etot4;
      for (int k = 0; k < ComponentCount; k++) begin
        p1_e[k]    <= e_in[k];
        p1_s[k]    <= s0[k];
        p2_e[k]    <= p1_e[k];
        p2_s[k]    <= p1_s[k];
        p2_h[k]    <= h1[k];
        p3_sig[k]  <= sig2[k];
        p3_e[k]    <= p2_e[k];
        p3_q[k]    <= q2[k];
        p3_qr[k]   <= qr2[k];
        p4_sig[k]  <= p3_sig[k];
        p4_a[k]    <= a3[k];
        p4_qrdt[k] <= qrdt3[k];
        p5_sig[k]  <= p4_sig[k];
      end
      if (p1_valid) begin
        fw_addr <= addr1;
        fw_h    <= h_row;
        fw_d    <= s_row;
      end
      if (p5_valid) begin
        fw_e_addr    <= addr5;
        fw_e_data    <= en_new;
        result_point <= p5_point;
        stress_xx <= p5_sig[0]; stress_yy <= p5_sig[1]; stress_zz <= p5_sig[2];
        stress_xy <= p5_sig[3]; stress_yz <= p5_sig[4]; stress_xz <= p5_sig[5];
        energy_total <= en_new;
      end
    end
  end

endmodule

@@ hdl/viscoelastic_sls_stress_update_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viscoelastic SLS stress update, top level
// Configuration registers, front classifier and back state update.
// ----------------------------------------------------------------------------
// One request per cycle is accepted while the queue has room. A request
// passes through a four-entry queue into a five-stage back pipeline (state
// read, history update, stress, energy terms, energy accumulation) and an
// output register. Requests for the same point may follow back to back,
// since the latest state writes are forwarded to the next read. A result
// that waits holds the whole back pipeline; the queue then fills and holds
// the input. A steady-state request updates the point state and gives no
// result. After reset a clearing pass zeroes the state of all POINT_COUNT
// points, during which requests queue but are not processed. The user must
// write registers only while no request is in flight; the block itself does
// not enforce this.
module viscoelastic_sls_stress_update_top import vsls_pkg::*; #(
  parameter int POINT_COUNT = DefPointCount,
  parameter int VALUE_WIDTH = DefValueWidth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 opcode,
  input  logic [PointIdxW-1:0] point_index,
  input  logic signed [31:0]   grad_xx, grad_xy, grad_xz,
  input  logic signed [31:0]   grad_yx, grad_yy, grad_yz,
  input  logic signed [31:0]   grad_zx, grad_zy, grad_zz,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PointIdxW-1:0] result_point,
  output logic signed [31:0]   stress_xx, stress_yy, stress_zz,
  output logic signed [31:0]   stress_xy, stress_yz, stress_xz,
  output logic signed [47:0]   energy_total
);

  localparam int VW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;

  cfg_t cfg;
  req_t q_data;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mu <= 31'd65536; cfg.k <= 31'd65536; cfg.gi <= 17'd0;
      cfg.gv <= 17'd65536; cfg.df <= 17'd65536; cfg.dh <= 17'd65536;
      cfg.alpha <= 31'd32768; cfg.sor <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MU:    cfg.mu    <= cfg_data[30:0];
        REG_K:     cfg.k     <= cfg_data[30:0];
        REG_GI:    cfg.gi    <= cfg_data[16:0];
        REG_GV:    cfg.gv    <= cfg_data[16:0];
        REG_DF:    cfg.df    <= cfg_data[16:0];
        REG_DH:    cfg.dh    <= cfg_data[16:0];
        REG_ALPHA: cfg.alpha <= cfg_data[30:0];
        REG_SOR:   cfg.sor   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  vsls_front #(.POINT_COUNT(POINT_COUNT), .VW(VW)) u_front (
    .clk, .rst, .in_valid, .in_ready, .opcode, .point_index,
    .grad_xx, .grad_xy, .grad_xz, .grad_yx, .grad_yy, .grad_yz,
    .grad_zx, .grad_zy, .grad_zz,
    .q_valid, .q_ready, .q_data
  );

  vsls_back #(.POINT_COUNT(POINT_COUNT), .VW(VW)) u_back (
    .clk, .rst, .cfg, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .result_point,
    .stress_xx, .stress_yy, .stress_zz, .stress_xy, .stress_yz, .stress_xz,
    .energy_total
  );

endmodule
